// ===== rtl/core/ufpc_pkg.sv =====
package ufpc_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned PAIR_W    = 20;
  localparam int unsigned TOTAL_W   = 21;
  localparam int unsigned PROD_W    = 2 * SIZE_W;
  localparam int unsigned SUM_W     = PROD_W + 2;

  // APB side: one 32-bit register per word
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = REG_IDX_W'(0);
  localparam logic [SIZE_W-1:0]    NODE_COUNT_RST = SIZE_W'(1024);

  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_JOIN  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic              merged;
    logic [SIZE_W-1:0] size_a;
    logic [SIZE_W-1:0] size_b;
    logic [PAIR_W-1:0] pair_count;
  } out_item_t;

endpackage

// ===== rtl/core/ufpc_ram.sv =====
module ufpc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/ufpc_regs.sv =====
module ufpc_regs
  import ufpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [SIZE_W-1:0]  node_count_o
);

  logic [SIZE_W-1:0] node_count_q, node_count_d;
  logic              hit;

  assign hit    = (paddr[PADDR_W-1:2] == REG_NODE_COUNT);
  assign pready = 1'b1;
  assign prdata = hit ? {{(PDATA_W-SIZE_W){1'b0}}, node_count_q} : '0;

  always_comb begin
    node_count_d = node_count_q;
    if (psel && penable && pwrite && hit) begin
      node_count_d = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else begin
      node_count_q <= node_count_d;
    end
  end

  assign node_count_o = node_count_q;

endmodule

// ===== rtl/core/ufpc_engine.sv =====
module ufpc_engine
  import ufpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] node_count_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  typedef enum logic [10:0] {
    S_SWEEP = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_FIND  = 11'b000_0000_0100,
    S_COMP  = 11'b000_0000_1000,
    S_SZ0   = 11'b000_0001_0000,
    S_SZ1   = 11'b000_0010_0000,
    S_SZ2   = 11'b000_0100_0000,
    S_MUL   = 11'b000_1000_0000,
    S_ADD   = 11'b001_0000_0000,
    S_LINK  = 11'b010_0000_0000,
    S_RESP  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // control
  logic              clr_q, clr_d;
  logic              side_q, side_d;
  logic              byp_q, byp_d;
  logic              out_valid_q, out_valid_d;
  logic [NODE_W-1:0] sweep_q, sweep_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // payload
  logic [NODE_W-1:0] a_q, a_d, b_q, b_d;
  logic [NODE_W-1:0] cur_q, cur_d, v_q, v_d;
  logic [NODE_W-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [SIZE_W-1:0] sa_q, sa_d, sb_q, sb_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              merged_q, merged_d;
  logic [NODE_W-1:0] byp_data_q, byp_data_d;
  out_item_t         res_q, res_d, out_data_q, out_data_d;

  // memory ports
  logic              p_we;
  logic [NODE_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata, p_data;
  logic              s_we;
  logic [NODE_W-1:0] s_waddr, s_raddr;
  logic [SIZE_W-1:0] s_wdata, s_rdata;

  logic [SIZE_W-1:0] limit;
  logic [PAIR_W-1:0] pair_sat;
  logic [SUM_W-1:0]  sum;
  logic [NODE_W-1:0] start;
  logic              side_done;

  ufpc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_parent (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  ufpc_ram #(.DEPTH(MAX_NODES), .WIDTH(SIZE_W)) u_size (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // a write in the same cycle as a read of that entry is forwarded
  assign p_data = byp_q ? byp_data_q : p_rdata;

  always_comb begin
    if (node_count_i == '0) begin
      limit = SIZE_W'(1);
    end else if (node_count_i > SIZE_W'(MAX_NODES)) begin
      limit = SIZE_W'(MAX_NODES);
    end else begin
      limit = node_count_i;
    end
  end

  assign pair_sat = total_q[TOTAL_W-1] ? '1 : total_q[PAIR_W-1:0];
  assign sum      = {{(SUM_W-TOTAL_W){1'b0}}, total_q} + {1'b0, prod_q, 1'b0};
  assign start    = side_q ? b_q : a_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    side_d      = side_q;
    sweep_d     = sweep_q;
    total_d     = total_q;
    a_d         = a_q;
    b_d         = b_q;
    cur_d       = cur_q;
    v_d         = v_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    prod_d      = prod_q;
    merged_d    = merged_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    p_we        = 1'b0;
    p_waddr     = v_q;
    p_wdata     = cur_q;
    p_raddr     = cur_q;
    s_we        = 1'b0;
    s_waddr     = ra_q;
    s_wdata     = '0;
    s_raddr     = ra_q;
    side_done   = 1'b0;

    unique case (state_q)
      S_SWEEP: begin
        p_we    = 1'b1;
        p_waddr = sweep_q;
        p_wdata = sweep_q;
        s_we    = 1'b1;
        s_waddr = sweep_q;
        s_wdata = SIZE_W'(1);
        sweep_d = sweep_q + NODE_W'(1);
        if (sweep_q == NODE_W'(MAX_NODES - 1)) begin
          total_d = '0;
          if (clr_q) begin
            res_d   = '0;
            state_d = S_RESP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        p_raddr = in_data_i.node_a;
        if (in_valid_i) begin
          a_d    = in_data_i.node_a;
          b_d    = in_data_i.node_b;
          cur_d  = in_data_i.node_a;
          side_d = 1'b0;
          if (in_data_i.action == ACT_CLEAR) begin
            clr_d   = 1'b1;
            sweep_d = '0;
            state_d = S_SWEEP;
          end else if (({1'b0, in_data_i.node_a} >= limit) ||
                       ({1'b0, in_data_i.node_b} >= limit)) begin
            res_d   = '{merged: 1'b0, size_a: '0, size_b: '0, pair_count: pair_sat};
            state_d = S_RESP;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (p_data == cur_q) begin
          if (side_q) rb_d = cur_q;
          else        ra_d = cur_q;
          if (start == cur_q) begin
            side_done = 1'b1;
          end else begin
            v_d     = start;
            p_raddr = start;
            state_d = S_COMP;
          end
        end else begin
          cur_d   = p_data;
          p_raddr = p_data;
        end
      end
      S_COMP: begin
        // point v at the root, step to its old parent
        p_we    = 1'b1;
        p_waddr = v_q;
        p_wdata = cur_q;
        v_d     = p_data;
        p_raddr = p_data;
        if (p_data == cur_q) begin
          side_done = 1'b1;
        end
      end
      S_SZ0: begin
        s_raddr = ra_q;
        state_d = S_SZ1;
      end
      S_SZ1: begin
        sa_d    = s_rdata;
        s_raddr = rb_q;
        state_d = S_SZ2;
      end
      S_SZ2: begin
        sb_d    = s_rdata;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d   = {{SIZE_W{1'b0}}, sa_q} * {{SIZE_W{1'b0}}, sb_q};
        merged_d = (ra_q != rb_q);
        state_d  = S_ADD;
      end
      S_ADD: begin
        if (merged_q) begin
          total_d = (sum[SUM_W-1:TOTAL_W] != '0) ? '1 : sum[TOTAL_W-1:0];
        end
        state_d = S_LINK;
      end
      S_LINK: begin
        if (merged_q) begin
          s_we    = 1'b1;
          s_wdata = SIZE_W'(sa_q + sb_q);
          p_we    = 1'b1;
          if (sa_q < sb_q) begin
            s_waddr = rb_q;
            p_waddr = ra_q;
            p_wdata = rb_q;
          end else begin
            s_waddr = ra_q;
            p_waddr = rb_q;
            p_wdata = ra_q;
          end
        end
        res_d   = '{merged: merged_q, size_a: sa_q, size_b: sb_q, pair_count: pair_sat};
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
          clr_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (side_done) begin
      if (!side_q) begin
        side_d  = 1'b1;
        cur_d   = b_q;
        p_raddr = b_q;
        state_d = S_FIND;
      end else begin
        state_d = S_SZ0;
      end
    end
  end

  assign byp_d      = p_we && (p_waddr == p_raddr);
  assign byp_data_d = p_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      clr_q       <= 1'b0;
      side_q      <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
      sweep_q     <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      side_q      <= side_d;
      byp_q       <= byp_d;
      out_valid_q <= out_valid_d;
      sweep_q     <= sweep_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    cur_q      <= cur_d;
    v_q        <= v_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    sa_q       <= sa_d;
    sb_q       <= sb_d;
    prod_q     <= prod_d;
    merged_q   <= merged_d;
    byp_data_q <= byp_data_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/union_find_pair_counter_top.sv =====
// Disjoint-set pair counter over a 1024-entry node table kept in two single-port-read
// memories (parent links and set sizes). After reset the block runs an init pass over
// both memories and holds in_stall_o high; a clear item runs the same pass and then
// returns its result. A join that names a node at or above the bound (node_count, with
// 0 read as 1 and above 1024 as 1024) goes straight to its result. A join walks the
// parent chain of node_a one memory read per cycle, rewrites that path one node per
// cycle, does the same for node_b, then steps through SZ0, SZ1, SZ2, MUL, ADD, LINK
// and RESP for sizes, count and linking. Items are worked one at a time; a finished
// result sits in an output register, so the next item is taken while it waits to
// transfer.
module union_find_pair_counter_top
  import ufpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  logic [SIZE_W-1:0] node_count;

  ufpc_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .node_count_o (node_count)
  );

  ufpc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  // the engine is always busy in the cycle after it accepts an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  // a new result only comes out of the busy engine
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while engine idle");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_NODE_COUNT))
      |=> (node_count == $past(pwdata[SIZE_W-1:0])))
    else $error("node_count write lost");
`endif

endmodule

// ===== tb/union_find_pair_counter_top_tb.sv =====
`timescale 1ns / 100ps

module union_find_pair_counter_top_tb;
  import ufpc_pkg::*;

  localparam logic [PADDR_W-1:0] NODE_COUNT_ADDR = PADDR_W'({REG_NODE_COUNT, 2'b00});
  localparam int unsigned QUIET_FROM = 2000;
  localparam int unsigned QUIET_TO   = 6000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned PHASE_LEN  = 45;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;

  union_find_pair_counter_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the disjoint-set forest
  logic [NODE_W-1:0] parent_link [MAX_NODES];
  int unsigned       set_size    [MAX_NODES];
  int unsigned       pair_total;
  logic [SIZE_W-1:0] node_cfg = NODE_COUNT_RST;

  in_item_t    item_backlog_q[$];
  out_item_t   forest_results_q[$];
  out_item_t   head_res;
  int unsigned transfers_in = 0;
  int unsigned mismatches   = 0;
  int unsigned cyc          = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  function automatic void init_forest();
    for (int i = 0; i < MAX_NODES; i++) begin
      parent_link[i] = NODE_W'(i);
      set_size[i]    = 1;
    end
    pair_total = 0;
  endfunction

  function automatic int unsigned effective_bound();
    if (node_cfg == 0) return 1;
    if (node_cfg > MAX_NODES) return MAX_NODES;
    return 32'(node_cfg);
  endfunction

  function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] r;
    logic [NODE_W-1:0] nxt;
    r = v;
    while (parent_link[r] != r) r = parent_link[r];
    // compress: every node on the path points straight at the root
    while (v != r) begin
      nxt            = parent_link[v];
      parent_link[v] = r;
      v              = nxt;
    end
    return r;
  endfunction

  function automatic out_item_t apply_to_forest(in_item_t it);
    out_item_t         res;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    logic [NODE_W-1:0] rt;
    int unsigned       lim;
    int unsigned       sa;
    int unsigned       sb;
    res = '0;
    lim = effective_bound();
    if (it.action == ACT_CLEAR) begin
      init_forest();
      return res;
    end
    if (it.node_a < lim && it.node_b < lim) begin
      ra = find_root(it.node_a);
      rb = find_root(it.node_b);
      sa = set_size[ra];
      sb = set_size[rb];
      res.size_a = SIZE_W'(sa);
      res.size_b = SIZE_W'(sb);
      if (ra != rb) begin
        pair_total += 2 * sa * sb;
        // smaller set goes under the larger; ties put b's root under a's
        if (sa < sb) begin
          rt = ra;
          ra = rb;
          rb = rt;
        end
        set_size[ra]    = sa + sb;
        parent_link[rb] = ra;
        res.merged      = 1'b1;
      end
    end
    res.pair_count = PAIR_W'(pair_total);
    return res;
  endfunction

  function automatic bit take_break();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  function automatic void report(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: exp merged=%0d size_a=%0d size_b=%0d pairs=%0d,",
                " got merged=%0d size_a=%0d size_b=%0d pairs=%0d"},
               $realtime, what, want.merged, want.size_a, want.size_b, want.pair_count,
               got.merged, got.size_a, got.size_b, got.pair_count);
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        forest_results_q.push_back(apply_to_forest(in_data_i));
        transfers_in <= transfers_in + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (item_backlog_q.size() != 0 && !take_break()) begin
          in_data_i  <= item_backlog_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off while items keep coming
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && transfers_in >= 40 && item_backlog_q.size() > 20) begin
      hold_left   <= HOLD_LEN;
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= take_break();
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (forest_results_q.size() == 0) begin
        report("unexpected result", '0, out_data_o);
      end else begin
        head_res = forest_results_q.pop_front();
        if (head_res.merged != out_data_o.merged || head_res.size_a != out_data_o.size_a ||
            head_res.size_b != out_data_o.size_b ||
            head_res.pair_count != out_data_o.pair_count)
          report("result mismatch", head_res, out_data_o);
      end
    end
  end

  task automatic push_join(input int unsigned a, input int unsigned b);
    in_item_t it;
    it.action = ACT_JOIN;
    it.node_a = NODE_W'(a);
    it.node_b = NODE_W'(b);
    item_backlog_q.push_back(it);
  endtask

  task automatic push_clear();
    in_item_t it;
    it.action = ACT_CLEAR;
    it.node_a = NODE_W'($urandom);
    it.node_b = NODE_W'($urandom);
    item_backlog_q.push_back(it);
  endtask

  task automatic await_idle();
    while (item_backlog_q.size() != 0 || in_valid_i || forest_results_q.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_node_count(input logic [SIZE_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    node_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata != PDATA_W'(value)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t node_count read-back: exp %0d got %0d", $realtime, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned count);
    int unsigned lim;
    int unsigned w;
    int unsigned base;
    int unsigned r;
    lim = effective_bound();
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        push_clear();
      end else if (r < 12) begin
        push_join($urandom_range(1023), $urandom_range(1023));
      end else if (r < 45) begin
        // tight window: many same-set hits and deeper compression
        w    = (lim < 12) ? lim : 12;
        base = $urandom_range(lim - w);
        push_join(base + $urandom_range(w - 1), base + $urandom_range(w - 1));
      end else begin
        push_join($urandom_range(lim - 1), $urandom_range(lim - 1));
      end
    end
    await_idle();
  endtask

  initial begin
    int unsigned bounds[10];
    bounds = '{16, 1024, 2, 64, 1, 300, 1024, 9, 1000, 0};
    bounds[9] = $urandom_range(1, 2047);
    init_forest();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_join(0, 1);
    push_join(1023, 1022);
    push_join(0, 1);
    push_join(1, 1023);
    push_join(5, 5);
    push_join(682, 341);
    push_join(1022, 3);
    push_join(3, 0);
    await_idle();

    // shrinking the bound keeps existing sets
    write_node_count(4);
    push_join(1, 0);
    push_join(4, 0);
    push_join(0, 4);
    push_join(1023, 1023);
    push_join(2, 3);
    push_clear();
    await_idle();

    write_node_count(0);
    push_join(0, 0);
    push_join(0, 1);
    push_join(1, 0);
    await_idle();

    // clamps to the full table; nodes above the old bound must be fresh after the clear
    write_node_count(2047);
    push_join(1023, 1022);
    push_join(1023, 0);
    await_idle();

    foreach (bounds[k]) begin
      write_node_count(SIZE_W'(bounds[k]));
      run_random_phase(PHASE_LEN);
    end

    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && forest_results_q.size() == 0) begin
      $display("union_find_pair_counter_top regression: pass");
    end else begin
      $display("union_find_pair_counter_top regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("union_find_pair_counter_top regression: fail");
    $finish;
  end

endmodule
